[design/cht_pkg.sv]
// Shared types and constants for the chained hash table.
package cht_pkg;

   // Fixed field widths
   localparam int KEY_W     = 31;
   localparam int PAYLOAD_W = 64;
   localparam int STATUS_W  = 3;

   // Key remainder unit: bits retired per cycle, padded key width, cycle count
   localparam int MOD_STEP   = 8;
   localparam int MOD_CYCLES = (KEY_W + MOD_STEP - 1) / MOD_STEP;
   localparam int KEY_PAD_W  = MOD_CYCLES * MOD_STEP;

   // Request commands
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_INS_PRIME   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INS_OVER    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FOUND_PRIME = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FOUND_OVER  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_POOL_FULL   = 3'd5;
   localparam logic [STATUS_W-1:0] ST_IGNORED     = 3'd6;

   // Control sequencer states
   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_MOD   = 5'b00100,
      S_BKT   = 5'b01000,
      S_POOL  = 5'b10000
   } state_type;

endpackage

[design/cht_mod.sv]
// Multi-cycle key remainder unit: key modulo BUCKETS, MOD_STEP bits per cycle.
module cht_mod #(
   parameter int BUCKETS = 10
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               go,
   input  logic [cht_pkg::KEY_W-1:0]          key,
   output logic                               done,
   output logic [$clog2(BUCKETS)-1:0]         remainder
);
   import cht_pkg::*;

   localparam int R_W   = $clog2(BUCKETS);
   localparam int CNT_W = (MOD_CYCLES > 1) ? $clog2(MOD_CYCLES) : 1;

   logic                 run_ff,   run_in;
   logic                 done_ff,  done_in;
   logic [CNT_W-1:0]     cnt_ff,   cnt_in;
   logic [R_W-1:0]       rem_ff,   rem_in;
   logic [KEY_PAD_W-1:0] shift_ff, shift_in;

   logic [R_W-1:0]       step_rem;
   logic [KEY_PAD_W-1:0] step_shift;
   logic [R_W:0]         trial;

   // Retire MOD_STEP key bits: shift one in, subtract the divisor when it fits
   always_comb begin
      step_rem   = rem_ff;
      step_shift = shift_ff;
      trial      = '0;
      for (int i = 0; i < MOD_STEP; i++) begin
         trial      = {step_rem, step_shift[KEY_PAD_W-1]};
         step_shift = {step_shift[KEY_PAD_W-2:0], 1'b0};
         if (trial >= (R_W+1)'(BUCKETS)) begin
            trial = trial - (R_W+1)'(BUCKETS);
         end
         step_rem = trial[R_W-1:0];
      end
   end

   // Load on go, advance while running, pulse done after the last step
   always_comb begin
      run_in   = run_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      shift_in = shift_ff;
      if (go) begin
         run_in   = 1'b1;
         cnt_in   = '0;
         rem_in   = '0;
         shift_in = KEY_PAD_W'(key);
      end else if (run_ff) begin
         rem_in   = step_rem;
         shift_in = step_shift;
         cnt_in   = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(MOD_CYCLES - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff   <= cnt_in;
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

[design/chained_hash_table_top.sv]
// Top level of the chained hash table: sequencer, bucket memory and overflow pool.
//
// Usage: drive req_command (0 insert, 1 search), req_key and req_payload and
// raise start; the request is taken at a clock edge where start is high and
// busy is low. Exactly one response follows: rsp_strobe is high for one cycle
// with rsp_status and rsp_found_payload, and the receiver cannot hold it off.
// A key of zero is answered as ignored in the cycle after it is taken.
// Sequence: the key remainder unit runs, then one bucket memory read and an
// evaluation step; inserts, prime-slot hits and searches with an empty chain
// respond after that step. A search that walks the overflow chain visits one
// node per cycle, one pool memory read each. busy drops in the cycle the
// response is shown, so a new request may be taken alongside it.
// Reset: after reset a clearing pass of BUCKETS cycles empties every bucket
// (prime key zero, chain head null); busy stays high during the pass.
// The overflow pool needs no clearing: a node is read only once linked.
module chained_hash_table_top #(
   parameter int BUCKETS   = 10,
   parameter int POOL_SIZE = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_command,
   input  logic [cht_pkg::KEY_W-1:0]         req_key,
   input  logic [cht_pkg::PAYLOAD_W-1:0]     req_payload,
   output logic                              rsp_strobe,
   output logic [cht_pkg::STATUS_W-1:0]      rsp_status,
   output logic [cht_pkg::PAYLOAD_W-1:0]     rsp_found_payload
);
   import cht_pkg::*;

   localparam int BKT_W   = $clog2(BUCKETS);
   localparam int LINK_W  = $clog2(POOL_SIZE + 1);
   localparam int PADDR_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_SIZE);

   // Bucket memory: prime key, prime payload, chain head
   logic [KEY_W-1:0]     bkt_key_mem  [BUCKETS];
   logic [PAYLOAD_W-1:0] bkt_pay_mem  [BUCKETS];
   logic [LINK_W-1:0]    bkt_head_mem [BUCKETS];
   // Overflow pool memory: key, payload, link
   logic [KEY_W-1:0]     pool_key_mem  [POOL_SIZE];
   logic [PAYLOAD_W-1:0] pool_pay_mem  [POOL_SIZE];
   logic [LINK_W-1:0]    pool_link_mem [POOL_SIZE];

   state_type            state_ff,  state_in;
   logic [BKT_W-1:0]     clr_ff,    clr_in;
   logic                 cmd_ff,    cmd_in;
   logic [KEY_W-1:0]     key_ff,    key_in;
   logic [PAYLOAD_W-1:0] payload_ff, payload_in;
   logic [BKT_W-1:0]     bkt_ff,    bkt_in;
   logic [LINK_W-1:0]    used_ff,   used_in;
   logic                 strobe_ff, strobe_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [PAYLOAD_W-1:0] found_ff,  found_in;

   logic [KEY_W-1:0]     bkt_key_rd_ff;
   logic [PAYLOAD_W-1:0] bkt_pay_rd_ff;
   logic [LINK_W-1:0]    bkt_head_rd_ff;
   logic [KEY_W-1:0]     pool_key_rd_ff;
   logic [PAYLOAD_W-1:0] pool_pay_rd_ff;
   logic [LINK_W-1:0]    pool_link_rd_ff;

   logic                 accept;
   logic                 mod_go;
   logic                 mod_done;
   logic [BKT_W-1:0]     mod_rem;

   logic                 bkt_re;
   logic                 bkt_key_we;
   logic                 bkt_pay_we;
   logic                 bkt_head_we;
   logic [BKT_W-1:0]     bkt_waddr;
   logic [KEY_W-1:0]     bkt_key_wdata;
   logic [LINK_W-1:0]    bkt_head_wdata;
   logic                 pool_we;
   logic                 pool_re;
   logic [PADDR_W-1:0]   pool_raddr;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // Bucket index of the request key, captured when the request is taken
   cht_mod #(
      .BUCKETS (BUCKETS)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .go        (mod_go),
      .key       (req_key),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // Sequence clearing, lookup, insert and chain walk
   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      cmd_in         = cmd_ff;
      key_in         = key_ff;
      payload_in     = payload_ff;
      bkt_in         = bkt_ff;
      used_in        = used_ff;
      strobe_in      = 1'b0;
      status_in      = status_ff;
      found_in       = found_ff;
      mod_go         = 1'b0;
      bkt_re         = 1'b0;
      bkt_key_we     = 1'b0;
      bkt_pay_we     = 1'b0;
      bkt_head_we    = 1'b0;
      bkt_waddr      = bkt_ff;
      bkt_key_wdata  = key_ff;
      bkt_head_wdata = used_ff;
      pool_we        = 1'b0;
      pool_re        = 1'b0;
      pool_raddr     = bkt_head_rd_ff[PADDR_W-1:0];
      unique case (state_ff)
         S_CLEAR: begin
            bkt_key_we     = 1'b1;
            bkt_head_we    = 1'b1;
            bkt_waddr      = clr_ff;
            bkt_key_wdata  = '0;
            bkt_head_wdata = NULL_LINK;
            clr_in         = clr_ff + BKT_W'(1);
            if (clr_ff == BKT_W'(BUCKETS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (req_key == '0) begin
                  strobe_in = 1'b1;
                  status_in = ST_IGNORED;
                  found_in  = '0;
               end else begin
                  cmd_in     = req_command;
                  key_in     = req_key;
                  payload_in = req_payload;
                  mod_go     = 1'b1;
                  state_in   = S_MOD;
               end
            end
         end
         S_MOD: begin
            // Issue the bucket read once the index is known
            if (mod_done) begin
               bkt_in   = mod_rem;
               bkt_re   = 1'b1;
               state_in = S_BKT;
            end
         end
         S_BKT: begin
            found_in = '0;
            if (cmd_ff == CMD_INSERT) begin
               strobe_in = 1'b1;
               state_in  = S_IDLE;
               if (bkt_key_rd_ff == '0) begin
                  bkt_key_we = 1'b1;
                  bkt_pay_we = 1'b1;
                  status_in  = ST_INS_PRIME;
               end else if (used_ff == NULL_LINK) begin
                  status_in = ST_POOL_FULL;
               end else begin
                  // Link the next free node at the head of the chain
                  pool_we     = 1'b1;
                  bkt_head_we = 1'b1;
                  used_in     = used_ff + LINK_W'(1);
                  status_in   = ST_INS_OVER;
               end
            end else if (bkt_key_rd_ff == key_ff) begin
               strobe_in = 1'b1;
               status_in = ST_FOUND_PRIME;
               found_in  = bkt_pay_rd_ff;
               state_in  = S_IDLE;
            end else if (bkt_head_rd_ff == NULL_LINK) begin
               strobe_in = 1'b1;
               status_in = ST_NOT_FOUND;
               state_in  = S_IDLE;
            end else begin
               pool_re  = 1'b1;
               state_in = S_POOL;
            end
         end
         S_POOL: begin
            // Compare one chain node, then follow its link
            found_in   = '0;
            pool_raddr = pool_link_rd_ff[PADDR_W-1:0];
            if (pool_key_rd_ff == key_ff) begin
               strobe_in = 1'b1;
               status_in = ST_FOUND_OVER;
               found_in  = pool_pay_rd_ff;
               state_in  = S_IDLE;
            end else if (pool_link_rd_ff == NULL_LINK) begin
               strobe_in = 1'b1;
               status_in = ST_NOT_FOUND;
               state_in  = S_IDLE;
            end else begin
               pool_re = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         used_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         used_ff   <= used_in;
         strobe_ff <= strobe_in;
      end
      cmd_ff     <= cmd_in;
      key_ff     <= key_in;
      payload_ff <= payload_in;
      bkt_ff     <= bkt_in;
      status_ff  <= status_in;
      found_ff   <= found_in;
   end

   // Bucket memory: one write address, one registered read
   always_ff @(posedge clock) begin
      if (bkt_key_we) begin
         bkt_key_mem[bkt_waddr] <= bkt_key_wdata;
      end
      if (bkt_pay_we) begin
         bkt_pay_mem[bkt_waddr] <= payload_ff;
      end
      if (bkt_head_we) begin
         bkt_head_mem[bkt_waddr] <= bkt_head_wdata;
      end
      if (bkt_re) begin
         bkt_key_rd_ff  <= bkt_key_mem[mod_rem];
         bkt_pay_rd_ff  <= bkt_pay_mem[mod_rem];
         bkt_head_rd_ff <= bkt_head_mem[mod_rem];
      end
   end

   // Overflow pool memory: one write address, one registered read
   always_ff @(posedge clock) begin
      if (pool_we) begin
         pool_key_mem[used_ff[PADDR_W-1:0]]  <= key_ff;
         pool_pay_mem[used_ff[PADDR_W-1:0]]  <= payload_ff;
         pool_link_mem[used_ff[PADDR_W-1:0]] <= bkt_head_rd_ff;
      end
      if (pool_re) begin
         pool_key_rd_ff  <= pool_key_mem[pool_raddr];
         pool_pay_rd_ff  <= pool_pay_mem[pool_raddr];
         pool_link_rd_ff <= pool_link_mem[pool_raddr];
      end
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_status        = status_ff;
   assign rsp_found_payload = found_ff;

endmodule
